>>> hdl/fvn_pkg.sv
// Shared constants and types for the fractal value noise block.
`timescale 1ns / 1ps
package fvn_pkg;

  localparam int MAX_OCTAVES_DEF = 8;
  localparam int FRAC_BITS_DEF   = 16;

  // lattice hash constants
  localparam logic [31:0] HASH_Z_MUL   = 32'd57;
  localparam int          HASH_SHIFT   = 13;
  localparam logic [31:0] HASH_C1      = 32'd15731;
  localparam logic [31:0] HASH_C2      = 32'd789221;
  localparam logic [31:0] HASH_C3      = 32'd1376312589;
  localparam logic [31:0] HASH_MASK    = 32'h7fff_ffff;
  localparam logic [31:0] LATTICE_ONE  = 32'h4000_0000;

  localparam int          AMP_W        = 17;
  localparam logic [16:0] GAIN_ONE     = 17'd65536;
  localparam logic [16:0] GAIN_RST     = 17'd32768;
  localparam logic [3:0]  OCT_CNT_RST  = 4'd4;
  localparam int          CFG_IDX_W    = 8;
  localparam int          CFG_DATA_W   = 17;
  localparam int          NOISE_W      = 18;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OCTAVE_COUNT = 8'd0,
    CFG_PERSISTENCE  = 8'd1
  } cfg_idx_e;

  // per-octave control traveling beside the data
  typedef struct packed {
    logic             first;
    logic             last;
    logic [AMP_W-1:0] amp;
  } oct_side_t;

endpackage

>>> hdl/fvn_hash.sv
// Three-stage pipelined 32-bit lattice hash producing a Q2.30 lattice value.
`timescale 1ns / 1ps
module fvn_hash (
  input  logic               clk_i,
  input  logic        [31:0] n_i,
  output logic signed [31:0] lattice_o
);
  import fvn_pkg::*;

  logic [31:0] n_a_q, sq_q, n_b_q, t_q;
  logic [31:0] h_w;

  assign h_w = (n_b_q * t_q + HASH_C3) & HASH_MASK;

  always_ff @(posedge clk_i) begin
    n_a_q     <= n_i;
    sq_q      <= n_i * n_i;
    n_b_q     <= n_a_q;
    t_q       <= sq_q * HASH_C1 + HASH_C2;
    lattice_o <= $signed(LATTICE_ONE - h_w);
  end

endmodule

>>> hdl/fbm_value_noise_2d.sv
// Top level: pipelined fractal 2D value noise with an octave issuer and a divider.
//
// Usage: pulse start_i with coord_x_i/coord_z_i (signed Q16.16) while busy_o is
// low; the item is taken at that edge. The block then issues one octave per
// cycle into a deep pipeline (split, 16 lattice hash units, smoothing, two lerp
// levels, amplitude weight, accumulate) and holds busy_o high until the last
// octave is issued, so a new item is taken only once the N octaves of the
// last are issued, N the clamped octave count (1 to MAX_OCTAVES, 8 by default;
// the reset count of 4 gives 4); the issuer, one octave per cycle, sets the pace.
// The normalizing divide is a 20-stage restoring divider, one quotient bit
// per stage, so several items are in flight at once.
// Output: noise_valid_o pulses for one cycle with noise_value_o (signed Q2.16,
// saturated) once the item's last octave has passed the divider. The receiver
// cannot stall; results are never held.
// Configuration: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i; ready
// is always high. Index 0 is octave_count, 1 is persistence_gain; others drop.
// Write configuration only when the block is idle.
// Reset: asynchronous, active low; clears all valid bits and loads register
// defaults (4 octaves, gain 0.5). No clearing pass is needed.
`timescale 1ns / 1ps
module fbm_value_noise_2d #(
  parameter int MAX_OCTAVES = fvn_pkg::MAX_OCTAVES_DEF,
  parameter int FRAC_BITS   = fvn_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic signed [31:0]                coord_x_i,
  input  logic signed [31:0]                coord_z_i,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [fvn_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [fvn_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output logic                              noise_valid_o,
  output logic signed [fvn_pkg::NOISE_W-1:0] noise_value_o
);
  import fvn_pkg::*;

  localparam int OCT_W = $clog2(MAX_OCTAVES + 1);
  localparam int IW    = 32 - FRAC_BITS;
  localparam int FW    = FRAC_BITS + 1;
  localparam int SW    = 36;
  localparam int DSW   = SW + 1;
  localparam int NW    = 40;
  localparam int P1W   = FW + DSW;
  localparam int P3W   = FW + NW + 1;
  localparam int WPW   = NW + AMP_W + 1;
  localparam int TW    = WPW + OCT_W;
  localparam int NRW   = AMP_W + OCT_W;
  localparam int DVW   = NRW + 18;
  localparam int QW    = 20;
  localparam int HLAT  = 3;
  localparam int CMPW  = OCT_W + 4;
  localparam logic signed [QW:0] SAT_MAX = (QW+1)'(131071);
  localparam logic signed [QW:0] SAT_MIN = -(QW+1)'(131072);

  // ---------------- configuration ----------------
  logic [3:0]       oct_count_q;
  logic [AMP_W-1:0] pers_gain_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oct_count_q <= OCT_CNT_RST;
      pers_gain_q <= GAIN_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == CFG_OCTAVE_COUNT) begin
        oct_count_q <= cfg_data_i[3:0];
      end else if (cfg_index_i == CFG_PERSISTENCE) begin
        pers_gain_q <= cfg_data_i;
      end
    end
  end

  // ---------------- octave issuer ----------------
  logic                    busy_q, accept;
  logic [OCT_W-1:0]        oct_idx_q, oct_lim_q, lim_w;
  logic [AMP_W-1:0]        gain_q, amp_q;
  logic [2*AMP_W-1:0]      amp_prod;
  logic signed [31:0]      cx_q, cz_q;
  logic                    iss_v_q;
  oct_side_t               iss_side_q;
  logic [CMPW-1:0]         cnt_ext;

  assign accept  = start_i && !busy_q;
  assign busy_o  = busy_q;
  assign cnt_ext = CMPW'(oct_count_q);

  always_comb begin
    if (cnt_ext == '0) begin
      lim_w = OCT_W'(1);
    end else if (cnt_ext > CMPW'(MAX_OCTAVES)) begin
      lim_w = OCT_W'(MAX_OCTAVES);
    end else begin
      lim_w = OCT_W'(cnt_ext);
    end
  end

  assign amp_prod = (2*AMP_W)'(amp_q) * (2*AMP_W)'(gain_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      iss_v_q   <= 1'b0;
      oct_idx_q <= '0;
      oct_lim_q <= OCT_W'(1);
    end else if (accept) begin
      busy_q    <= (lim_w > OCT_W'(1));
      iss_v_q   <= 1'b1;
      oct_idx_q <= OCT_W'(1);
      oct_lim_q <= lim_w;
    end else if (busy_q) begin
      busy_q    <= (oct_idx_q != oct_lim_q - OCT_W'(1));
      iss_v_q   <= 1'b1;
      oct_idx_q <= oct_idx_q + OCT_W'(1);
    end else begin
      iss_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cx_q             <= coord_x_i;
      cz_q             <= coord_z_i;
      amp_q            <= GAIN_ONE;
      gain_q           <= (pers_gain_q > GAIN_ONE) ? GAIN_ONE : pers_gain_q;
      iss_side_q.first <= 1'b1;
      iss_side_q.last  <= (lim_w == OCT_W'(1));
      iss_side_q.amp   <= GAIN_ONE;
    end else if (busy_q) begin
      // advance one octave: double coordinates, scale amplitude
      cx_q             <= cx_q <<< 1;
      cz_q             <= cz_q <<< 1;
      amp_q            <= AMP_W'(amp_prod >> 16);
      iss_side_q.first <= 1'b0;
      iss_side_q.last  <= (oct_idx_q == oct_lim_q - OCT_W'(1));
      iss_side_q.amp   <= AMP_W'(amp_prod >> 16);
    end
  end

  // ---------------- split and hash input ----------------
  logic signed [31:0] flr_x, flr_z;
  logic               adj_x, adj_z;
  logic signed [IW-1:0] ixs, izs;
  logic [31:0]        ix32, iz32;
  logic signed [FW-1:0] fx_w, fz_w;

  assign flr_x = cx_q >>> FRAC_BITS;
  assign flr_z = cz_q >>> FRAC_BITS;
  // truncate toward zero: bump the floor for negative values with a fraction
  assign adj_x = cx_q[31] && (|cx_q[FRAC_BITS-1:0]);
  assign adj_z = cz_q[31] && (|cz_q[FRAC_BITS-1:0]);
  assign ixs   = IW'(flr_x) + IW'(adj_x);
  assign izs   = IW'(flr_z) + IW'(adj_z);
  assign ix32  = 32'(ixs);
  assign iz32  = 32'(izs);
  assign fx_w  = {adj_x, cx_q[FRAC_BITS-1:0]};
  assign fz_w  = {adj_z, cz_q[FRAC_BITS-1:0]};

  logic [31:0]          n_q [16];
  logic                 b_v_q;
  oct_side_t            b_side_q;
  logic signed [FW-1:0] b_fx_q, b_fz_q;
  logic signed [31:0]   lat_w [16];

  for (genvar a = 0; a < 4; a++) begin : g_hx
    for (genvar b = 0; b < 4; b++) begin : g_hz
      logic [31:0] xa, zb, n0;
      assign xa = ix32 + 32'(a - 1);
      assign zb = iz32 + 32'(b - 1);
      assign n0 = xa + zb * HASH_Z_MUL;
      always_ff @(posedge clk_i) begin
        n_q[a*4+b] <= (n0 << HASH_SHIFT) ^ n0;
      end
      fvn_hash u_hash (
        .clk_i     (clk_i),
        .n_i       (n_q[a*4+b]),
        .lattice_o (lat_w[a*4+b])
      );
    end
  end

  // side data delayed alongside the hash units
  logic                 hd_v_q    [HLAT];
  oct_side_t            hd_side_q [HLAT];
  logic signed [FW-1:0] hd_fx_q   [HLAT];
  logic signed [FW-1:0] hd_fz_q   [HLAT];

  // ---------------- smoothing through output ----------------
  logic signed [SW-1:0]  s_w [4];
  logic signed [SW-1:0]  s_q [4];
  logic                  f_v_q, g_v_q, h_v_q, i_v_q, j_v_q, k_v_q;
  oct_side_t             f_side_q, g_side_q, h_side_q, i_side_q, j_side_q, k_side_q;
  logic signed [FW-1:0]  f_fx_q, f_fz_q, g_fz_q, h_fz_q;
  logic signed [P1W-1:0] p1_q, p2_q;
  logic signed [SW-1:0]  g_s00_q, g_s01_q;
  logic signed [NW-1:0]  i1_q, i2_q, i_i1_q, noise_q;
  logic signed [P3W-1:0] p3_q;
  logic signed [WPW-1:0] wp_q;

  for (genvar a = 0; a < 2; a++) begin : g_sx
    for (genvar b = 0; b < 2; b++) begin : g_sz
      localparam int PX = a + 1;
      localparam int PZ = b + 1;
      logic signed [SW-1:0] cs, es;
      assign cs = SW'(lat_w[(PX-1)*4+PZ-1]) + SW'(lat_w[(PX+1)*4+PZ-1])
                + SW'(lat_w[(PX-1)*4+PZ+1]) + SW'(lat_w[(PX+1)*4+PZ+1]);
      assign es = SW'(lat_w[(PX-1)*4+PZ]) + SW'(lat_w[(PX+1)*4+PZ])
                + SW'(lat_w[PX*4+PZ-1]) + SW'(lat_w[PX*4+PZ+1]);
      assign s_w[a*2+b] = cs + (es <<< 1) + (SW'(lat_w[PX*4+PZ]) <<< 2);
    end
  end

  logic signed [DSW-1:0] d1_w, d2_w;
  logic signed [NW:0]    d3_w;

  assign d1_w = DSW'(s_q[2]) - DSW'(s_q[0]);
  assign d2_w = DSW'(s_q[3]) - DSW'(s_q[1]);
  assign d3_w = (NW+1)'(i2_q) - (NW+1)'(i1_q);

  always_ff @(posedge clk_i) begin
    b_side_q <= iss_side_q;
    b_fx_q   <= fx_w;
    b_fz_q   <= fz_w;
    hd_side_q[0] <= b_side_q;
    hd_fx_q[0]   <= b_fx_q;
    hd_fz_q[0]   <= b_fz_q;
    for (int k = 1; k < HLAT; k++) begin
      hd_side_q[k] <= hd_side_q[k-1];
      hd_fx_q[k]   <= hd_fx_q[k-1];
      hd_fz_q[k]   <= hd_fz_q[k-1];
    end
    // smooth the four cell corners
    for (int k = 0; k < 4; k++) begin
      s_q[k] <= s_w[k];
    end
    f_side_q <= hd_side_q[HLAT-1];
    f_fx_q   <= hd_fx_q[HLAT-1];
    f_fz_q   <= hd_fz_q[HLAT-1];
    // first lerp level: products
    p1_q     <= P1W'(f_fx_q) * P1W'(d1_w);
    p2_q     <= P1W'(f_fx_q) * P1W'(d2_w);
    g_s00_q  <= s_q[0];
    g_s01_q  <= s_q[1];
    g_side_q <= f_side_q;
    g_fz_q   <= f_fz_q;
    // first lerp level: floor shift and add
    i1_q     <= NW'(g_s00_q) + NW'(p1_q >>> FRAC_BITS);
    i2_q     <= NW'(g_s01_q) + NW'(p2_q >>> FRAC_BITS);
    h_side_q <= g_side_q;
    h_fz_q   <= g_fz_q;
    // second lerp level
    p3_q     <= P3W'(h_fz_q) * P3W'(d3_w);
    i_i1_q   <= i1_q;
    i_side_q <= h_side_q;
    noise_q  <= i_i1_q + NW'(p3_q >>> FRAC_BITS);
    j_side_q <= i_side_q;
    // weight by amplitude
    wp_q     <= WPW'(noise_q) * WPW'($signed({1'b0, j_side_q.amp}));
    k_side_q <= j_side_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q <= 1'b0;
      for (int k = 0; k < HLAT; k++) begin
        hd_v_q[k] <= 1'b0;
      end
      f_v_q <= 1'b0;
      g_v_q <= 1'b0;
      h_v_q <= 1'b0;
      i_v_q <= 1'b0;
      j_v_q <= 1'b0;
      k_v_q <= 1'b0;
    end else begin
      b_v_q     <= iss_v_q;
      hd_v_q[0] <= b_v_q;
      for (int k = 1; k < HLAT; k++) begin
        hd_v_q[k] <= hd_v_q[k-1];
      end
      f_v_q <= hd_v_q[HLAT-1];
      g_v_q <= f_v_q;
      h_v_q <= g_v_q;
      i_v_q <= h_v_q;
      j_v_q <= i_v_q;
      k_v_q <= j_v_q;
    end
  end

  // ---------------- accumulate ----------------
  logic signed [TW-1:0] acc_total_q;
  logic [NRW-1:0]       acc_norm_q;
  logic                 fin_v_q;

  always_ff @(posedge clk_i) begin
    if (k_v_q) begin
      acc_total_q <= (k_side_q.first ? '0 : acc_total_q) + TW'(wp_q);
      acc_norm_q  <= (k_side_q.first ? '0 : acc_norm_q) + NRW'(k_side_q.amp);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_v_q <= 1'b0;
    end else begin
      fin_v_q <= k_v_q && k_side_q.last;
    end
  end

  // ---------------- restoring divider, one quotient bit per stage ----------------
  logic [TW-1:0]  rem_q [QW+1];
  logic [QW-1:0]  quo_q [QW+1];
  logic [DVW-1:0] dvs_q [QW+1];
  logic           sgn_q [QW+1];
  logic           dv_v_q [QW+1];

  always_ff @(posedge clk_i) begin
    rem_q[0] <= acc_total_q[TW-1] ? TW'(-acc_total_q) : TW'(acc_total_q);
    quo_q[0] <= '0;
    dvs_q[0] <= {acc_norm_q, 18'd0};
    sgn_q[0] <= acc_total_q[TW-1];
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    localparam int BIT = QW - 1 - j;
    logic [TW-1:0] trial;
    logic          ge;
    assign trial = TW'(dvs_q[j]) << BIT;
    assign ge    = (rem_q[j] >= trial);
    always_ff @(posedge clk_i) begin
      rem_q[j+1] <= ge ? rem_q[j] - trial : rem_q[j];
      quo_q[j+1] <= {quo_q[j][QW-2:0], ge};
      dvs_q[j+1] <= dvs_q[j];
      sgn_q[j+1] <= sgn_q[j];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= QW; k++) begin
        dv_v_q[k] <= 1'b0;
      end
    end else begin
      dv_v_q[0] <= fin_v_q;
      for (int k = 1; k <= QW; k++) begin
        dv_v_q[k] <= dv_v_q[k-1];
      end
    end
  end

  // ---------------- sign, saturate, output ----------------
  logic signed [QW:0] res_w;

  assign res_w = sgn_q[QW] ? -$signed({1'b0, quo_q[QW]}) : $signed({1'b0, quo_q[QW]});

  always_ff @(posedge clk_i) begin
    priority if (res_w > SAT_MAX) begin
      noise_value_o <= NOISE_W'(SAT_MAX);
    end else if (res_w < SAT_MIN) begin
      noise_value_o <= NOISE_W'(SAT_MIN);
    end else begin
      noise_value_o <= NOISE_W'(res_w);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      noise_valid_o <= 1'b0;
    end else begin
      noise_valid_o <= dv_v_q[QW];
    end
  end

  // ---------------- assertions ----------------
  a_issue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (oct_idx_q < oct_lim_q))
    else $error("octave index ran past the octave limit");

  a_norm_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_v_q |-> (acc_norm_q != '0))
    else $error("amplitude sum is zero at divide");

  a_quo_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_v_q[QW] |-> (rem_q[QW] < TW'(dvs_q[QW])))
    else $error("quotient overflowed the divider width");

endmodule

>>> tb/sv/tb_top.sv
// Self-checking testbench for the fractal 2D value noise block.
`timescale 1ns / 1ps
module tb_top;
  import fvn_pkg::*;

  typedef struct {
    logic [31:0] x;
    logic [31:0] z;
  } point_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start_i = 1'b0;
  logic                 busy_o;
  logic signed [31:0]   coord_x_i = '0;
  logic signed [31:0]   coord_z_i = '0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                 noise_valid_o;
  logic signed [NOISE_W-1:0] noise_value_o;

  point_t              pending_pts[$];
  logic [NOISE_W-1:0]  noise_expect[$];
  logic [3:0]          oct_cfg = OCT_CNT_RST;
  logic [16:0]         gain_cfg = GAIN_RST;
  int                  idle_pct = 0;
  int                  n_sent = 0;
  int                  n_checked = 0;
  int                  n_errors = 0;
  int                  n_settings = 0;

  fbm_value_noise_2d dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .coord_x_i, .coord_z_i,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .noise_valid_o, .noise_value_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic longint lattice_hash(logic [31:0] ix, logic [31:0] iz);
    logic [31:0] n;
    logic [31:0] t;
    logic [31:0] h;
    n = ix + iz * HASH_Z_MUL;
    n = (n << HASH_SHIFT) ^ n;
    t = n * n * HASH_C1 + HASH_C2;
    h = (n * t + HASH_C3) & HASH_MASK;
    return longint'(LATTICE_ONE) - longint'(h);
  endfunction

  function automatic longint blend(longint a, longint b, longint f);
    return a + ((f * (b - a)) >>> FRAC_BITS_DEF);
  endfunction

  // one octave, result in units of 2^-34
  function automatic longint octave_value(longint cx, longint cz);
    longint ixs, izs, fx, fz, c, e, i1, i2;
    longint g[4][4];
    longint s[2][2];
    logic [31:0] ix, iz;
    ixs = cx / 65536;
    izs = cz / 65536;
    fx = cx - ixs * 65536;
    fz = cz - izs * 65536;
    ix = ixs[31:0];
    iz = izs[31:0];
    for (int a = 0; a < 4; a++)
      for (int b = 0; b < 4; b++)
        g[a][b] = lattice_hash(ix + 32'(a) - 32'd1, iz + 32'(b) - 32'd1);
    for (int a = 0; a < 2; a++)
      for (int b = 0; b < 2; b++) begin
        c = g[a][b] + g[a+2][b] + g[a][b+2] + g[a+2][b+2];
        e = g[a][b+1] + g[a+2][b+1] + g[a+1][b] + g[a+1][b+2];
        s[a][b] = c + 2 * e + 4 * g[a+1][b+1];
      end
    i1 = blend(s[0][0], s[1][0], fx);
    i2 = blend(s[0][1], s[1][1], fx);
    return blend(i1, i2, fz);
  endfunction

  function automatic logic [NOISE_W-1:0] fbm_noise(logic [31:0] x, logic [31:0] z);
    longint total, norm, amp, gain, r;
    int oct;
    logic [31:0] xs, zs;
    total = 0;
    norm = 0;
    amp = 65536;
    gain = (gain_cfg > GAIN_ONE) ? 65536 : longint'(gain_cfg);
    oct = int'(oct_cfg);
    if (oct < 1) oct = 1;
    if (oct > MAX_OCTAVES_DEF) oct = MAX_OCTAVES_DEF;
    for (int i = 0; i < oct; i++) begin
      xs = x << i;
      zs = z << i;
      total += octave_value(longint'($signed(xs)), longint'($signed(zs))) * amp;
      norm += amp;
      amp = (amp * gain) >> 16;
    end
    r = total / (norm * 262144);
    if (r > 131071) r = 131071;
    if (r < -131072) r = -131072;
    return r[NOISE_W-1:0];
  endfunction

  // driver: hold the item until taken, then advance or idle
  always @(posedge clk_i or negedge rst_ni) begin
    point_t p;
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else begin
      if (start_i && !busy_o) begin
        noise_expect.push_back(fbm_noise(coord_x_i, coord_z_i));
        n_sent++;
      end
      if (!start_i || !busy_o) begin
        if (pending_pts.size() > 0 && $urandom_range(99) >= idle_pct) begin
          p = pending_pts.pop_front();
          start_i <= 1'b1;
          coord_x_i <= p.x;
          coord_z_i <= p.z;
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    logic [NOISE_W-1:0] want;
    if (rst_ni && noise_valid_o) begin
      if (noise_expect.size() == 0) begin
        $display("%0t: unexpected noise_value %0d", $time, noise_value_o);
        n_errors++;
      end else begin
        want = noise_expect.pop_front();
        if (noise_value_o !== want) begin
          $display("%0t: noise_value expected %0d actual %0d", $time,
                   $signed(want), noise_value_o);
          n_errors++;
        end
        n_checked++;
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_OCTAVE_COUNT) oct_cfg = data[3:0];
    else if (idx == CFG_PERSISTENCE) gain_cfg = data;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic add_point(logic [31:0] x, logic [31:0] z);
    point_t p;
    p.x = x;
    p.z = z;
    pending_pts.push_back(p);
  endtask

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(4))
      0, 1:    return $urandom();
      2:       return 32'($signed($urandom_range(32'h0020_0000)) - 32'sh0010_0000);
      3:       return {16'h7fff ^ {16{$urandom_range(1) == 1}}, 16'($urandom())};
      default: return {$urandom_range(1) == 1 ? 16'hffff : 16'h0000, 16'($urandom())};
    endcase
  endfunction

  task automatic drain();
    while (pending_pts.size() > 0 || start_i || noise_expect.size() > 0)
      @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  initial begin
    logic [31:0] edges[10];
    edges = '{32'h0, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'h0001_0000,
              32'hffff_0000, 32'h0000_8000, 32'hffff_8000, 32'h0000_ffff, 32'h4000_0001};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset settings, field extremes, negative fractions, shift wrap
    for (int i = 0; i < 10; i++) add_point(edges[i], edges[(i * 3 + 1) % 10]);
    add_point(32'h7fff_ffff, 32'h7fff_ffff);
    add_point(32'h8000_0000, 32'h8000_0000);
    drain();
    n_settings++;
    write_reg(CFG_OCTAVE_COUNT, 17'd8);
    write_reg(CFG_PERSISTENCE, 17'd65536);
    for (int i = 0; i < 6; i++) add_point(edges[i], edges[9 - i]);
    drain();
    write_reg(CFG_OCTAVE_COUNT, 17'd0);   // clamps to one octave
    write_reg(CFG_PERSISTENCE, 17'h1ffff); // above one, treated as one
    write_reg(8'd2, 17'd3);                // unknown index, drop
    write_reg(8'hff, 17'd1);
    for (int i = 0; i < 6; i++) add_point(edges[9 - i], edges[i]);
    drain();
    n_settings += 2;

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin write_reg(CFG_OCTAVE_COUNT, 17'd1);  write_reg(CFG_PERSISTENCE, 17'd0); end
        1: begin write_reg(CFG_OCTAVE_COUNT, 17'd8);  write_reg(CFG_PERSISTENCE, 17'd65536); end
        2: begin write_reg(CFG_OCTAVE_COUNT, 17'd15); write_reg(CFG_PERSISTENCE, 17'd1); end
        3: begin write_reg(CFG_OCTAVE_COUNT, 17'd4);  write_reg(CFG_PERSISTENCE, 17'd32768); end
        default: begin
          write_reg(CFG_OCTAVE_COUNT, 17'($urandom_range(15)));
          write_reg(CFG_PERSISTENCE, 17'($urandom_range(17'h1ffff)));
        end
      endcase
      // receiver cannot stall, so the phases vary only the sender's idle percentage
      case (ph % 4)
        0: idle_pct = 0;
        1: idle_pct = 49;
        2: idle_pct = 0;
        default: idle_pct = 26;
      endcase
      for (int i = 0; i < 250; i++) add_point(pick_coord(), pick_coord());
      drain();
      n_settings++;
    end

    $display("tb_top: %0d points sent, %0d noise values checked, %0d settings",
             n_sent, n_checked, n_settings);
    $display("tb_top: octave counts 0..15, gains 0..above one, idle 0/26/49 pct");
    if (n_errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
